// ===== rtl/core/rip_pkg.sv =====
// Package for the resource identifier pool: request and status codes,
// field widths, controller states and the controller/datapath structs.
// No dependencies.
`default_nettype none

package rip_pkg;

  localparam int ID_W    = 32;
  localparam int COUNT_W = 9;

  localparam logic [1:0] REQ_CLEAR   = 2'd0;
  localparam logic [1:0] REQ_ADD     = 2'd1;
  localparam logic [1:0] REQ_ACQUIRE = 2'd2;
  localparam logic [1:0] REQ_RELEASE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NONE_FREE = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Identifier reported when no identifier is returned (minus one).
  localparam logic signed [ID_W-1:0] ID_NONE = '1;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_EMIT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // request word taken this cycle
    logic scan;    // scan in progress
    logic emit;    // load the result into the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;        // scanned entry matches this cycle
    logic exhausted;  // no match within the filled entries
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rip_if.sv =====
// Request and response channel interfaces of the resource identifier pool.
// Depends on rip_pkg.
`default_nettype none

interface rip_req_if import rip_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic signed [ID_W-1:0] conn_id;

  modport source (output valid, output req_type, output conn_id, input ready);
  modport sink   (input valid, input req_type, input conn_id, output ready);
endinterface

interface rip_rsp_if import rip_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic signed [ID_W-1:0] id_out;
  logic [COUNT_W-1:0]     entry_count;

  modport source (output valid, output status, output id_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input id_out, input entry_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rip_ctrl.sv =====
// Controller of the resource identifier pool: request acceptance, scan
// sequencing and output register handshake. Depends on rip_pkg.
`default_nettype none

module rip_ctrl import rip_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_kind,
  output logic            in_ready,
  input  wire logic       out_ready,
  output logic            out_valid,
  input  wire dp_stat_t   stat,
  output ctl_cmd_t        cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      CTL_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_kind inside {REQ_ACQUIRE, REQ_RELEASE}) begin
            state_next = CTL_SCAN;
          end else begin
            state_next = CTL_EMIT;
          end
        end
      end
      CTL_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.exhausted) begin
          state_next = CTL_EMIT;
        end
      end
      CTL_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = CTL_IDLE;
        end
      end
      default: begin
        state_next = CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // A new result never overwrites one that is still waiting.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting result");

  // A scanning request always leads to the scan state.
  a_scan_entry: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && (in_kind == REQ_ACQUIRE || in_kind == REQ_RELEASE))
      |=> (state == CTL_SCAN))
    else $error("acquire or release did not start a scan");

  // The scan cannot both match and run out in one cycle.
  a_hit_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !(stat.hit && stat.exhausted))
    else $error("scan hit and exhausted together");

endmodule

`default_nettype wire

// ===== rtl/core/rip_dp.sv =====
// Datapath of the resource identifier pool: entry memory with busy bits,
// fill count, scan pointer and result registers. Depends on rip_pkg.
`default_nettype none

module rip_dp import rip_pkg::*; #(
  parameter int POOL_DEPTH = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ctl_cmd_t               cmd,
  input  wire logic [1:0]             req_type,
  input  wire logic signed [ID_W-1:0] conn_id,
  output dp_stat_t                    stat,
  output logic [1:0]                  status,
  output logic signed [ID_W-1:0]      id_out,
  output logic [COUNT_W-1:0]          entry_count
);

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);

  // Each entry holds the busy bit above the identifier. Add writes the busy
  // bit clear, so entries at or above the fill count never need clearing.
  logic [ID_W:0] mem [POOL_DEPTH];

  logic [CW-1:0]          count;
  logic [CW-1:0]          issue_idx;
  logic                   rd_valid;
  logic [AW-1:0]          rd_addr;
  logic [ID_W:0]          rd_data;
  logic [1:0]             op;
  logic signed [ID_W-1:0] key;
  logic [1:0]             res_status;
  logic signed [ID_W-1:0] res_id;

  logic                   full;
  logic                   issue;
  logic                   match;
  logic                   add_we;
  logic                   we;
  logic [AW-1:0]          wa;
  logic [ID_W:0]          wd;
  logic [CW+COUNT_W-1:0]  count_ext;

  assign full  = (count >= CW'(POOL_DEPTH));
  assign match = (op == REQ_ACQUIRE) ? !rd_data[ID_W] : (rd_data[ID_W-1:0] == key);

  assign stat.hit       = cmd.scan && rd_valid && match;
  assign stat.exhausted = cmd.scan && !rd_valid && !(issue_idx < count);

  assign issue  = cmd.scan && !stat.hit && (issue_idx < count);
  assign add_we = cmd.accept && (req_type == REQ_ADD) && !full;

  always_comb begin
    we = 1'b0;
    wa = rd_addr;
    wd = rd_data;
    if (add_we) begin
      we = 1'b1;
      wa = count[AW-1:0];
      wd = {1'b0, conn_id};
    end else if (stat.hit) begin
      we = 1'b1;
      wd = {(op == REQ_ACQUIRE), rd_data[ID_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (issue) begin
      rd_data <= mem[issue_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (cmd.accept && req_type == REQ_CLEAR) begin
        count <= '0;
      end else if (add_we) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_addr   <= issue_idx[AW-1:0];
      issue_idx <= issue_idx + 1'b1;
    end
    if (cmd.accept) begin
      op        <= req_type;
      key       <= conn_id;
      issue_idx <= '0;
      res_id    <= ID_NONE;
      case (req_type)
        REQ_CLEAR:   res_status <= ST_OK;
        REQ_ADD:     res_status <= full ? ST_FULL : ST_OK;
        REQ_ACQUIRE: res_status <= ST_NONE_FREE;
        default:     res_status <= ST_NOT_FOUND;
      endcase
    end else if (stat.hit) begin
      res_status <= ST_OK;
      if (op == REQ_ACQUIRE) begin
        res_id <= rd_data[ID_W-1:0];
      end
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status      <= res_status;
      id_out      <= res_id;
      entry_count <= count_ext[COUNT_W-1:0];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(POOL_DEPTH))
    else $error("fill count above pool depth");

  a_read_filled: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (CW'(rd_addr) < count))
    else $error("scan read beyond the filled entries");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    add_we |=> (count == $past(count) + 1'b1))
    else $error("add did not advance the fill count");

endmodule

`default_nettype wire

// ===== rtl/core/resource_id_pool.sv =====
// Top level of the resource identifier pool: joins the controller and the
// datapath to the request and response channels. Depends on rip_pkg, rip_if,
// rip_ctrl and rip_dp.
`default_nettype none

// Channel  Modport  Word contents
// -------  -------  -----------------------------------------------
// req      sink     req_type (2 bits), conn_id (32 bits, signed)
// rsp      source   status (2 bits), id_out (32 bits, signed),
//                   entry_count (9 bits)
//
// Clear and add go from acceptance straight to the emit state. Acquire and
// release scan the entry memory one entry per cycle through its registered
// read port, stopping at the first match or at the fill count, and then go
// to the emit state; on an empty pool the scan ends before any read.
// Reset clears only the fill count, the read-valid flag, the control state and
// the output valid flag; no clearing pass. A result waits in the output
// register while the next word is accepted; a stalled response holds the block before it loads the following result.

module resource_id_pool import rip_pkg::*; #(
  parameter int POOL_DEPTH = 256
) (
  input wire logic clk,
  input wire logic rst,
  rip_req_if.sink  req,
  rip_rsp_if.source rsp
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // The controller sees only the handshake, the request kind and the datapath
  // status; all payload handling stays in the datapath.
  rip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_kind   (req.req_type),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  rip_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req.req_type),
    .conn_id     (req.conn_id),
    .stat        (stat),
    .status      (rsp.status),
    .id_out      (rsp.id_out),
    .entry_count (rsp.entry_count)
  );

endmodule

`default_nettype wire
